FILE: hdl/vmtr_pkg.sv
// -----------------------------------------------------------------------------
// vmtr_pkg: shared types and constants for the VTOL mode transition ramp
// Field widths, blend fixed-point format and configuration register indexes.
// -----------------------------------------------------------------------------
package vmtr_pkg;

    // Blend fraction is unsigned Q1.FRAC_BITS; 1 << FRAC_BITS means 1.0
    localparam int FRAC_BITS = 16;
    localparam int BLEND_W   = FRAC_BITS + 1;

    localparam int SPEED_W   = 16;
    localparam int STEP_W    = 20;
    localparam int DUR_W     = 24;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // Dividend of the blend step: step_us << FRAC_BITS
    localparam int DIVD_W    = STEP_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    localparam logic [BLEND_W-1:0] BLEND_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STALL_SPEED    = 2'd0,
        REG_TRANS_BAND     = 2'd1,
        REG_CONFIRM_TARGET = 2'd2,
        REG_TRANS_TIME     = 2'd3
    } t_cfg_idx;

endpackage

FILE: hdl/vmtr_if.sv
// -----------------------------------------------------------------------------
// vmtr_if: valid/ready channels of the VTOL mode transition ramp
// Tick input channel, result output channel and configuration write channel.
// -----------------------------------------------------------------------------
interface vmtr_in_if
    import vmtr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed;
    logic               fixed_wing_request;
    logic [STEP_W-1:0]  step_us;

    modport source (output valid, speed, fixed_wing_request, step_us, input ready);
    modport sink   (input valid, speed, fixed_wing_request, step_us, output ready);
endinterface

interface vmtr_out_if
    import vmtr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               flight_mode;
    logic [BLEND_W-1:0] blend_fraction;
    logic [CNT_W-1:0]   confirm_level;
    logic               input_error;

    modport source (output valid, flight_mode, blend_fraction, confirm_level, input_error,
                    input ready);
    modport sink   (input valid, flight_mode, blend_fraction, confirm_level, input_error,
                    output ready);
endinterface

interface vmtr_cfg_if
    import vmtr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/vtol_mode_transition_ramp_core.sv
// -----------------------------------------------------------------------------
// vtol_mode_transition_ramp_core: VTOL flight-mode switch with blend ramp
// Confirmation counter with speed hysteresis, mode decision and a blend
// fraction ramped by step_us / transition_time_us through a serial divider.
// -----------------------------------------------------------------------------
// Usage:
//   i_in   tick beat: speed (Q8.8 m/s), fixed_wing_request, step_us.
//   o_out  result beat: flight_mode, blend_fraction (Q1.16), confirm_level,
//          input_error.
//   i_cfg  register writes (index, data); always ready, write only when idle.
// Timing:
//   One tick is taken at a time; i_in.ready is high only while the sequencer
//   is idle. A tick that moves the blend runs the restoring divider one
//   quotient bit per cycle over 36 bits (step_us << 16), then ST_APPLY
//   updates the blend and ST_DONE loads the result register; the next tick
//   can be taken once the result register has loaded. A tick with a zero
//   step or a mode change goes from ST_EVAL straight to ST_DONE.
// Reset (synchronous, active low) restores the register defaults, clears
// mode, blend and counter, and empties the result register.
// A stalled receiver holds the result register; a new tick is still taken
// and worked, and its result waits in the sequencer until the register frees.
// -----------------------------------------------------------------------------
module vtol_mode_transition_ramp_core
    import vmtr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    vmtr_in_if.sink    i_in,
    vmtr_out_if.source o_out,
    vmtr_cfg_if.sink   i_cfg
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_APPLY = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Configuration registers
    logic [SPEED_W-1:0] r_stall_speed;
    logic [SPEED_W-1:0] r_trans_band;
    logic [CNT_W-1:0]   r_confirm_target;
    logic [DUR_W-1:0]   r_trans_time;

    // Block state
    logic               r_mode;
    logic [BLEND_W-1:0] r_blend;
    logic [CNT_W-1:0]   r_cnt;

    // Sequencer and working registers
    t_state             r_state, n_state;
    logic [SPEED_W-1:0] r_speed;
    logic               r_request;
    logic [STEP_W-1:0]  r_step;
    logic               r_err;
    logic [DUR_W-1:0]   r_div;
    logic [DUR_W-1:0]   r_rem;
    logic [DIVD_W-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_bit_cnt;

    // Result register
    logic               r_out_valid;
    logic               r_out_mode;
    logic [BLEND_W-1:0] r_out_blend;
    logic [CNT_W-1:0]   r_out_cnt;
    logic               r_out_err;

    logic               in_fire;
    logic               out_load;

    // Counter and mode decision signals
    logic [SPEED_W:0]   up_limit;
    logic [CNT_W-1:0]   n_cnt;
    logic [CNT_W-1:0]   threshold;
    logic               n_mode;
    logic               mode_change;

    // Divider step signals
    logic [DUR_W:0]     trial;
    logic               trial_ge;
    logic [DUR_W:0]     trial_diff;

    // Blend update signals
    logic [BLEND_W-1:0] delta;
    logic [BLEND_W:0]   blend_sum;
    logic [BLEND_W-1:0] n_blend;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // Confirmation counter with hysteresis, then mode decision on the new count
    always_comb begin
        up_limit = {1'b0, r_stall_speed} + {1'b0, r_trans_band};
        n_cnt    = r_cnt;
        if (r_speed <= r_stall_speed) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end else if ({1'b0, r_speed} > up_limit) begin
            if (r_cnt < r_confirm_target) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
        threshold   = (r_confirm_target == '0) ? '0 : r_confirm_target - CNT_W'(1);
        n_mode      = r_mode;
        mode_change = 1'b0;
        if (r_mode) begin
            if (!r_request || n_cnt <= CNT_W'(1)) begin
                n_mode      = 1'b0;
                mode_change = 1'b1;
            end
        end else if (r_request && n_cnt >= threshold) begin
            n_mode      = 1'b1;
            mode_change = 1'b1;
        end
    end

    // One restoring division step: shift in the next dividend bit, try subtract
    always_comb begin
        trial      = {r_rem, r_quo[DIVD_W-1]};
        trial_diff = trial - {1'b0, r_div};
        trial_ge   = (trial >= {1'b0, r_div});
    end

    // Clamp the step to 1.0 and ramp toward the active mode
    always_comb begin
        delta     = (r_quo > DIVD_W'(BLEND_ONE)) ? BLEND_ONE : r_quo[BLEND_W-1:0];
        blend_sum = {1'b0, r_blend} + {1'b0, delta};
        if (r_mode) begin
            n_blend = (blend_sum > {1'b0, BLEND_ONE}) ? BLEND_ONE : blend_sum[BLEND_W-1:0];
        end else begin
            n_blend = (r_blend > delta) ? r_blend - delta : '0;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_step == '0 || mode_change) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bit_cnt == '0) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_speed    <= SPEED_W'(3840);
            r_trans_band     <= SPEED_W'(1280);
            r_confirm_target <= CNT_W'(10);
            r_trans_time     <= DUR_W'(2000000);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_STALL_SPEED:    r_stall_speed    <= i_cfg.data[SPEED_W-1:0];
                REG_TRANS_BAND:     r_trans_band     <= i_cfg.data[SPEED_W-1:0];
                REG_CONFIRM_TARGET: r_confirm_target <= i_cfg.data[CNT_W-1:0];
                REG_TRANS_TIME:     r_trans_time     <= i_cfg.data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= 1'b0;
            r_blend <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EVAL && r_step != '0) begin
                r_cnt  <= n_cnt;
                r_mode <= n_mode;
            end
            if (r_state == ST_APPLY) begin
                r_blend <= n_blend;
            end
        end
    end

    // Capture the tick and run the divider
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_speed   <= i_in.speed;
            r_request <= i_in.fixed_wing_request;
            r_step    <= i_in.step_us;
        end
        if (r_state == ST_EVAL) begin
            r_err     <= (r_step == '0);
            r_div     <= (r_trans_time == '0) ? DUR_W'(1) : r_trans_time;
            r_rem     <= '0;
            r_quo     <= {r_step, {FRAC_BITS{1'b0}}};
            r_bit_cnt <= DIV_CNT_W'(DIVD_W - 1);
        end else if (r_state == ST_DIV) begin
            r_rem     <= trial_ge ? trial_diff[DUR_W-1:0] : trial[DUR_W-1:0];
            r_quo     <= {r_quo[DIVD_W-2:0], trial_ge};
            r_bit_cnt <= r_bit_cnt - DIV_CNT_W'(1);
        end
    end

    // Result register: load when free or being drained, drop on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mode  <= r_mode;
            r_out_blend <= r_blend;
            r_out_cnt   <= r_cnt;
            r_out_err   <= r_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.flight_mode    = r_out_mode;
    assign o_out.blend_fraction = r_out_blend;
    assign o_out.confirm_level  = r_out_cnt;
    assign o_out.input_error    = r_out_err;

endmodule

FILE: hdl/vmtr_checker.sv
// -----------------------------------------------------------------------------
// vmtr_checker: port-level checks for the VTOL mode transition ramp
// Watches the tick and result channels of the top level through a bind.
// -----------------------------------------------------------------------------
module vmtr_checker
    import vmtr_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_mode,
    input logic [BLEND_W-1:0] i_out_blend,
    input logic [CNT_W-1:0]   i_out_cnt,
    input logic               i_out_err
);

    // One tick at a time: ready drops right after a tick beat
    a_busy_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("tick taken while previous tick still in work");

    // Blend never leaves 0..1.0
    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_blend <= BLEND_ONE)
        else $error("blend fraction above 1.0");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mode)
            && $stable(i_out_blend) && $stable(i_out_cnt) && $stable(i_out_err))
        else $error("stalled result beat changed");

endmodule

bind vtol_mode_transition_ramp_core vmtr_checker u_vmtr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mode  (o_out.flight_mode),
    .i_out_blend (o_out.blend_fraction),
    .i_out_cnt   (o_out.confirm_level),
    .i_out_err   (o_out.input_error)
);
